// File: rtl/sprt_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the sorted sparse row table.
// Used by sprt_mem, sprt_mul and sorted_sparse_row_table_unit.
package sprt_pkg;

    // default configuration
    localparam int DEPTH_DEF      = 64;
    localparam int INDEX_BITS_DEF = 16;
    localparam int VALUE_BITS_DEF = 32;

    // Q16.16 fraction and multiplier slice width
    localparam int FRAC_BITS = 16;
    localparam int MUL_CHUNK = 16;

    // fixed field widths
    localparam int REQ_BITS    = 2;
    localparam int STATUS_BITS = 3;
    localparam int COUNT_BITS  = 7;

    // request codes
    localparam logic [REQ_BITS-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_SCALE  = 2'd2;

    // status codes
    localparam logic [STATUS_BITS-1:0] STAT_OVERWRITE = 3'd0;
    localparam logic [STATUS_BITS-1:0] STAT_INSERT    = 3'd1;
    localparam logic [STATUS_BITS-1:0] STAT_DROP      = 3'd2;
    localparam logic [STATUS_BITS-1:0] STAT_HIT       = 3'd3;
    localparam logic [STATUS_BITS-1:0] STAT_MISS      = 3'd4;
    localparam logic [STATUS_BITS-1:0] STAT_SCALED    = 3'd5;

    // memory port control
    typedef struct packed {
        logic rd_en;
        logic we_col;
        logic we_val;
    } mem_ctl_t;

endpackage

// File: rtl/sprt_mem.sv
`timescale 1ns / 1ps
// Column and value storage: one registered read port, one write port.
// Depends on sprt_pkg for the port control struct.
module sprt_mem #(
    parameter int DEPTH      = sprt_pkg::DEPTH_DEF,
    parameter int INDEX_BITS = sprt_pkg::INDEX_BITS_DEF,
    parameter int VALUE_BITS = sprt_pkg::VALUE_BITS_DEF,
    localparam int ADDR_W    = $clog2(DEPTH)
) (
    input  logic                   clk,
    input  sprt_pkg::mem_ctl_t     ctl,
    input  logic [ADDR_W-1:0]      rd_addr,
    input  logic [ADDR_W-1:0]      wr_addr,
    input  logic [INDEX_BITS-1:0]  wr_col,
    input  logic [VALUE_BITS-1:0]  wr_val,
    output logic [INDEX_BITS-1:0]  rd_col,
    output logic [VALUE_BITS-1:0]  rd_val
);

    logic [INDEX_BITS-1:0] col_mem [DEPTH];
    logic [VALUE_BITS-1:0] val_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.we_col)
        begin
            col_mem[wr_addr] <= wr_col;
        end
        if (ctl.we_val)
        begin
            val_mem[wr_addr] <= wr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_col <= col_mem[rd_addr];
            rd_val <= val_mem[rd_addr];
        end
    end

endmodule

// File: rtl/sprt_mul.sv
`timescale 1ns / 1ps
// Multi-cycle signed Q16.16 multiply with floor rounding and saturation.
// Depends on sprt_pkg for the fraction and slice widths.
module sprt_mul #(
    parameter int VALUE_BITS = sprt_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic signed [VALUE_BITS-1:0] factor,
    output logic                         done,
    output logic signed [VALUE_BITS-1:0] result
);

    localparam int CHUNK = sprt_pkg::MUL_CHUNK;
    localparam int FRAC  = sprt_pkg::FRAC_BITS;
    localparam int NCH   = (VALUE_BITS + CHUNK - 1) / CHUNK;
    localparam int BPAD  = NCH * CHUNK;
    localparam int PW    = VALUE_BITS + BPAD;
    localparam int QW    = PW - FRAC;
    localparam int KW    = $clog2(NCH + 1);

    typedef enum logic [1:0] {
        M_IDLE,
        M_RUN,
        M_RND,
        M_SAT
    } mstate_t;

    mstate_t                 state_reg;
    logic [VALUE_BITS-1:0]   a_reg;
    logic [BPAD-1:0]         b_reg;
    logic                    neg_reg;
    logic [PW-1:0]           acc_reg;
    logic [QW-1:0]           q_reg;
    logic [KW-1:0]           k_reg;
    logic                    done_reg;
    logic [VALUE_BITS-1:0]   result_reg;

    logic [VALUE_BITS-1:0]         a_mag;
    logic [VALUE_BITS-1:0]         b_mag;
    logic [VALUE_BITS+CHUNK-1:0]   prod;
    logic [PW-1:0]                 acc_next;
    logic [QW-1:0]                 q_next;
    logic [VALUE_BITS-1:0]         limit;
    logic [VALUE_BITS-1:0]         sat_mag;

    assign a_mag = value[VALUE_BITS-1]  ? $unsigned(-value)  : $unsigned(value);
    assign b_mag = factor[VALUE_BITS-1] ? $unsigned(-factor) : $unsigned(factor);

    // most significant slice first, accumulator shifts up each step
    assign prod     = a_reg * b_reg[BPAD-1 -: CHUNK];
    assign acc_next = (acc_reg << CHUNK) + PW'(prod);

    // floor of a negative product: bump the magnitude when fraction bits are lost
    assign q_next = acc_reg[PW-1:FRAC]
                  + QW'(neg_reg && (acc_reg[FRAC-1:0] != '0));

    assign limit   = neg_reg ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                             : {1'b0, {(VALUE_BITS-1){1'b1}}};
    assign sat_mag = (q_reg > QW'(limit)) ? limit : q_reg[VALUE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == M_SAT);
            case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= a_mag;
                        b_reg     <= BPAD'(b_mag);
                        neg_reg   <= value[VALUE_BITS-1] ^ factor[VALUE_BITS-1];
                        acc_reg   <= '0;
                        k_reg     <= '0;
                        state_reg <= M_RUN;
                    end
                end
                M_RUN:
                begin
                    acc_reg <= acc_next;
                    b_reg   <= b_reg << CHUNK;
                    k_reg   <= k_reg + KW'(1);
                    if (k_reg == KW'(NCH - 1))
                    begin
                        state_reg <= M_RND;
                    end
                end
                M_RND:
                begin
                    q_reg     <= q_next;
                    state_reg <= M_SAT;
                end
                M_SAT:
                begin
                    result_reg <= neg_reg ? (~sat_mag + VALUE_BITS'(1)) : sat_mag;
                    state_reg  <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = $signed(result_reg);

endmodule

// File: rtl/sorted_sparse_row_table_unit.sv
`timescale 1ns / 1ps
// Sorted sparse row table: control sequencer, result register, memory and multiplier.
// Depends on sprt_pkg, sprt_mem and sprt_mul.
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+-----
//  in      | in_valid, in_ready, req_type, col_index,         | in
//          | entry_value, scale_factor                        |
//  out     | out_valid, out_ready, status, read_value,        | out
//          | entry_count                                      |
//
// One request at a time; the table memory read port sets the pace.
// Lookup and overwrite scan up from the first entry to the key's position. Insert
// searches, then moves each entry above the new slot up one. Scale reads,
// multiplies and writes back each stored entry, bound by the multi-cycle multiplier. Other codes end in a miss.
// A new request is taken while a finished result waits in the output register.
// Reset empties the table at once; no clearing pass.
module sorted_sparse_row_table_unit #(
    parameter int DEPTH      = sprt_pkg::DEPTH_DEF,
    parameter int INDEX_BITS = sprt_pkg::INDEX_BITS_DEF,
    parameter int VALUE_BITS = sprt_pkg::VALUE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [sprt_pkg::REQ_BITS-1:0]        req_type,
    input  logic [INDEX_BITS-1:0]                col_index,
    input  logic signed [VALUE_BITS-1:0]         entry_value,
    input  logic signed [VALUE_BITS-1:0]         scale_factor,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sprt_pkg::STATUS_BITS-1:0]     status,
    output logic signed [VALUE_BITS-1:0]         read_value,
    output logic [sprt_pkg::COUNT_BITS-1:0]      entry_count
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int STAT_W = sprt_pkg::STATUS_BITS;
    localparam int COUT_W = sprt_pkg::COUNT_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_SC_ISSUE,
        S_SC_LOAD,
        S_SC_WAIT,
        S_DONE
    } state_t;

    state_t                          state_reg;
    logic [sprt_pkg::REQ_BITS-1:0]   req_reg;
    logic [INDEX_BITS-1:0]           key_reg;
    logic [VALUE_BITS-1:0]           val_reg;
    logic [VALUE_BITS-1:0]           fac_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [CNT_W-1:0]                iss_reg;
    logic [CNT_W-1:0]                pos_reg;
    logic [ADDR_W-1:0]               chk_reg;
    logic                            dv_reg;
    logic [STAT_W-1:0]               stat_reg;
    logic [VALUE_BITS-1:0]           rdv_reg;
    logic                            out_valid_reg;
    logic [STAT_W-1:0]               ostat_reg;
    logic [VALUE_BITS-1:0]           oval_reg;
    logic [COUT_W-1:0]               ocnt_reg;

    sprt_pkg::mem_ctl_t              ctl;
    logic [ADDR_W-1:0]               rd_addr;
    logic [ADDR_W-1:0]               wr_addr;
    logic [INDEX_BITS-1:0]           wr_col;
    logic [VALUE_BITS-1:0]           wr_val;
    logic [INDEX_BITS-1:0]           rd_col;
    logic [VALUE_BITS-1:0]           rd_val;

    logic                            mul_start;
    logic                            mul_done;
    logic signed [VALUE_BITS-1:0]    mul_result;

    logic                            hit;
    logic                            past_key;
    logic                            search_end;

    sprt_mem #(
        .DEPTH      (DEPTH),
        .INDEX_BITS (INDEX_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_mem (
        .clk     (clk),
        .ctl     (ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_col  (wr_col),
        .wr_val  (wr_val),
        .rd_col  (rd_col),
        .rd_val  (rd_val)
    );

    sprt_mul #(
        .VALUE_BITS (VALUE_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .value  ($signed(rd_val)),
        .factor ($signed(fac_reg)),
        .done   (mul_done),
        .result (mul_result)
    );

    assign hit        = dv_reg && (rd_col == key_reg);
    assign past_key   = dv_reg && (rd_col > key_reg);
    assign search_end = !dv_reg && (iss_reg == cnt_reg);

    // memory port requests
    always_comb
    begin
        ctl       = '0;
        rd_addr   = '0;
        wr_addr   = '0;
        wr_col    = key_reg;
        wr_val    = val_reg;
        mul_start = 1'b0;
        case (state_reg)
            S_SEARCH:
            begin
                if (iss_reg < cnt_reg)
                begin
                    ctl.rd_en = 1'b1;
                    rd_addr   = iss_reg[ADDR_W-1:0];
                end
                if ((req_reg == sprt_pkg::REQ_ADD) && hit)
                begin
                    ctl.we_val = 1'b1;
                    wr_addr    = chk_reg;
                end
            end
            S_SHIFT:
            begin
                // walk down from the top, moving each entry up one slot
                if (iss_reg > pos_reg)
                begin
                    ctl.rd_en = 1'b1;
                    rd_addr   = ADDR_W'(iss_reg - CNT_W'(1));
                end
                if (dv_reg)
                begin
                    ctl.we_col = 1'b1;
                    ctl.we_val = 1'b1;
                    wr_addr    = chk_reg + ADDR_W'(1);
                    wr_col     = rd_col;
                    wr_val     = rd_val;
                end
                else if (iss_reg == pos_reg)
                begin
                    ctl.we_col = 1'b1;
                    ctl.we_val = 1'b1;
                    wr_addr    = pos_reg[ADDR_W-1:0];
                end
            end
            S_SC_ISSUE:
            begin
                if (iss_reg < cnt_reg)
                begin
                    ctl.rd_en = 1'b1;
                    rd_addr   = iss_reg[ADDR_W-1:0];
                end
            end
            S_SC_LOAD:
            begin
                mul_start = 1'b1;
            end
            S_SC_WAIT:
            begin
                if (mul_done)
                begin
                    ctl.we_val = 1'b1;
                    wr_addr    = iss_reg[ADDR_W-1:0];
                    wr_val     = $unsigned(mul_result);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            iss_reg       <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // completion reloads the output register itself
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg <= req_type;
                        key_reg <= col_index;
                        val_reg <= $unsigned(entry_value);
                        fac_reg <= $unsigned(scale_factor);
                        iss_reg <= '0;
                        dv_reg  <= 1'b0;
                        rdv_reg <= '0;
                        case (req_type)
                            sprt_pkg::REQ_ADD,
                            sprt_pkg::REQ_LOOKUP:
                            begin
                                state_reg <= S_SEARCH;
                            end
                            sprt_pkg::REQ_SCALE:
                            begin
                                state_reg <= S_SC_ISSUE;
                            end
                            default:
                            begin
                                stat_reg  <= sprt_pkg::STAT_MISS;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SEARCH:
                begin
                    if (hit)
                    begin
                        if (req_reg == sprt_pkg::REQ_ADD)
                        begin
                            stat_reg <= sprt_pkg::STAT_OVERWRITE;
                        end
                        else
                        begin
                            stat_reg <= sprt_pkg::STAT_HIT;
                            rdv_reg  <= rd_val;
                        end
                        state_reg <= S_DONE;
                    end
                    else if (past_key || search_end)
                    begin
                        if (req_reg != sprt_pkg::REQ_ADD)
                        begin
                            stat_reg  <= sprt_pkg::STAT_MISS;
                            state_reg <= S_DONE;
                        end
                        else if (cnt_reg == CNT_W'(DEPTH))
                        begin
                            stat_reg  <= sprt_pkg::STAT_DROP;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            pos_reg   <= past_key ? CNT_W'(chk_reg) : cnt_reg;
                            iss_reg   <= cnt_reg;
                            dv_reg    <= 1'b0;
                            state_reg <= S_SHIFT;
                        end
                    end
                    else if (iss_reg < cnt_reg)
                    begin
                        chk_reg <= iss_reg[ADDR_W-1:0];
                        iss_reg <= iss_reg + CNT_W'(1);
                        dv_reg  <= 1'b1;
                    end
                    else
                    begin
                        dv_reg <= 1'b0;
                    end
                end
                S_SHIFT:
                begin
                    if (iss_reg > pos_reg)
                    begin
                        chk_reg <= ADDR_W'(iss_reg - CNT_W'(1));
                        iss_reg <= iss_reg - CNT_W'(1);
                        dv_reg  <= 1'b1;
                    end
                    else
                    begin
                        dv_reg <= 1'b0;
                    end
                    if (!dv_reg && (iss_reg == pos_reg))
                    begin
                        cnt_reg   <= cnt_reg + CNT_W'(1);
                        stat_reg  <= sprt_pkg::STAT_INSERT;
                        state_reg <= S_DONE;
                    end
                end
                S_SC_ISSUE:
                begin
                    if (iss_reg < cnt_reg)
                    begin
                        state_reg <= S_SC_LOAD;
                    end
                    else
                    begin
                        stat_reg  <= sprt_pkg::STAT_SCALED;
                        state_reg <= S_DONE;
                    end
                end
                S_SC_LOAD:
                begin
                    state_reg <= S_SC_WAIT;
                end
                S_SC_WAIT:
                begin
                    if (mul_done)
                    begin
                        iss_reg   <= iss_reg + CNT_W'(1);
                        state_reg <= S_SC_ISSUE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        ostat_reg     <= stat_reg;
                        oval_reg      <= rdv_reg;
                        ocnt_reg      <= COUT_W'(cnt_reg);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = ostat_reg;
    assign read_value  = $signed(oval_reg);
    assign entry_count = ocnt_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cnt_reg) |-> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("entry count changed by other than one");

    a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.rd_en && (ctl.we_col || ctl.we_val)) |-> (rd_addr != wr_addr))
        else $error("read and write to the same entry in one cycle");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside completion");

    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_SC_WAIT))
        else $error("multiplier finished with no scale in progress");

endmodule
